>>> design/rrbc_pkg.sv
`timescale 1ns / 1ps

package rrbc_pkg;

    localparam int RAM_BANKS_DEF  = 4;
    localparam int RAM_BANK_BYTES = 8192;
    localparam int ROM_BANKS_MAX  = 128;

    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int ROM_ADDR_W  = 21;
    localparam int ROM_BANK_W  = 7;
    localparam int LOW_BANK_W  = 5;
    localparam int HIGH_BANK_W = 2;
    localparam int RAM_SEL_W   = 2;
    localparam int BANK_OFF_W  = $clog2(RAM_BANK_BYTES);
    localparam int ROM_OFF_W   = 14;
    localparam int SRC_W       = 2;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [APB_AW-1:0] REG_ROM_BANK_COUNT = 4'h0;
    localparam logic [APB_AW-1:0] REG_RAM_BANK_COUNT = 4'h4;
    localparam logic [APB_AW-1:0] REG_HAS_RAM        = 4'h8;

    localparam logic [7:0] ROM_BANK_COUNT_RST = 8'd2;
    localparam logic [2:0] RAM_BANK_COUNT_RST = 3'd1;
    localparam logic       HAS_RAM_RST        = 1'b0;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [SRC_W-1:0] SRC_ROM      = 2'd0;
    localparam logic [SRC_W-1:0] SRC_RAM      = 2'd1;
    localparam logic [SRC_W-1:0] SRC_RAM_OFF  = 2'd2;
    localparam logic [SRC_W-1:0] SRC_INVALID  = 2'd3;

    localparam logic [3:0]        RAM_EN_KEY     = 4'hA;
    localparam logic [DATA_W-1:0] RAM_OFF_DATA   = 8'hFF;
    localparam logic [LOW_BANK_W-1:0] LOW_BANK_MASK = 5'h1F;

    typedef struct packed {
        logic [7:0] rom_bank_count;
        logic [2:0] ram_bank_count;
        logic       has_ram;
    } t_cfg;

    typedef struct packed {
        logic                  ram_enabled;
        logic [ROM_BANK_W-1:0] active_rom_bank;
        logic [RAM_SEL_W-1:0]  active_ram_bank;
    } t_bank_state;

    typedef struct packed {
        logic              wr;
        logic [ADDR_W-1:0] bus_address;
        logic [DATA_W-1:0] write_value;
    } t_bank_wr;

endpackage

>>> design/rrbc_in_if.sv
`timescale 1ns / 1ps

interface rrbc_in_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [rrbc_pkg::ADDR_W-1:0]  bus_address;
    logic [rrbc_pkg::DATA_W-1:0]  write_value;

    modport src (output valid, cmd, bus_address, write_value, input ready);
    modport snk (input valid, cmd, bus_address, write_value, output ready);
endinterface

>>> design/rrbc_out_if.sv
`timescale 1ns / 1ps

interface rrbc_out_if;
    logic                            valid;
    logic                            ready;
    logic [rrbc_pkg::SRC_W-1:0]      source;
    logic [rrbc_pkg::ROM_ADDR_W-1:0] rom_address;
    logic [rrbc_pkg::DATA_W-1:0]     read_data;

    modport src (output valid, source, rom_address, read_data, input ready);
    modport snk (input valid, source, rom_address, read_data, output ready);
endinterface

>>> design/rrbc_cfg.sv
`timescale 1ns / 1ps

module rrbc_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rrbc_pkg::APB_AW-1:0] paddr,
    input  logic [rrbc_pkg::APB_DW-1:0] pwdata,
    output logic [rrbc_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output rrbc_pkg::t_cfg              o_cfg
);

    rrbc_pkg::t_cfg r_cfg;
    logic           wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rom_bank_count <= rrbc_pkg::ROM_BANK_COUNT_RST;
            r_cfg.ram_bank_count <= rrbc_pkg::RAM_BANK_COUNT_RST;
            r_cfg.has_ram        <= rrbc_pkg::HAS_RAM_RST;
        end else if (wr_en) begin
            case (paddr)
                rrbc_pkg::REG_ROM_BANK_COUNT: r_cfg.rom_bank_count <= pwdata[7:0];
                rrbc_pkg::REG_RAM_BANK_COUNT: r_cfg.ram_bank_count <= pwdata[2:0];
                rrbc_pkg::REG_HAS_RAM:        r_cfg.has_ram        <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            rrbc_pkg::REG_ROM_BANK_COUNT: prdata = {24'd0, r_cfg.rom_bank_count};
            rrbc_pkg::REG_RAM_BANK_COUNT: prdata = {29'd0, r_cfg.ram_bank_count};
            rrbc_pkg::REG_HAS_RAM:        prdata = {31'd0, r_cfg.has_ram};
            default:                      prdata = '0;
        endcase
    end

endmodule

>>> design/rrbc_bank.sv
`timescale 1ns / 1ps

module rrbc_bank #(
    parameter int RAM_BANKS = rrbc_pkg::RAM_BANKS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rrbc_pkg::t_cfg        i_cfg,
    input  rrbc_pkg::t_bank_wr    i_wr,
    output rrbc_pkg::t_bank_state o_state
);

    logic                                r_ram_enabled;
    logic                                r_rom_mode;
    logic [rrbc_pkg::LOW_BANK_W-1:0]     r_low_bank;
    logic [rrbc_pkg::HIGH_BANK_W-1:0]    r_high_bank;
    logic [rrbc_pkg::ROM_BANK_W-1:0]     r_rom_bank;
    logic [rrbc_pkg::RAM_SEL_W-1:0]      r_ram_bank;

    logic [rrbc_pkg::LOW_BANK_W-1:0]     n_low_bank;
    logic [rrbc_pkg::HIGH_BANK_W-1:0]    n_high_bank;
    logic [rrbc_pkg::ROM_BANK_W-1:0]     rom_mask;
    logic [rrbc_pkg::ROM_BANK_W-1:0]     n_rom_bank;
    logic [rrbc_pkg::RAM_SEL_W-1:0]      sel;
    logic [2:0]                          region;
    logic                                ram_sel_ok;

    assign region = i_wr.bus_address[15:13];
    assign sel    = i_wr.write_value[rrbc_pkg::RAM_SEL_W-1:0];

    assign ram_sel_ok = ({1'b0, sel} < i_cfg.ram_bank_count)
                     && (32'(sel) < 32'(RAM_BANKS));

    always_comb begin
        n_low_bank  = r_low_bank;
        n_high_bank = r_high_bank;
        if (region == 3'd1) begin
            n_low_bank = i_wr.write_value[rrbc_pkg::LOW_BANK_W-1:0] & rrbc_pkg::LOW_BANK_MASK;
            if (n_low_bank == '0) begin
                n_low_bank = rrbc_pkg::LOW_BANK_W'(1);
            end
        end
        if (region == 3'd2) begin
            n_high_bank = sel;
        end
        rom_mask   = rrbc_pkg::ROM_BANK_W'(i_cfg.rom_bank_count - 8'd1)
                   & rrbc_pkg::ROM_BANK_W'(rrbc_pkg::ROM_BANKS_MAX - 1);
        n_rom_bank = {n_high_bank, n_low_bank} & rom_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_enabled <= 1'b0;
            r_rom_mode    <= 1'b1;
            r_low_bank    <= rrbc_pkg::LOW_BANK_W'(1);
            r_high_bank   <= '0;
            r_rom_bank    <= rrbc_pkg::ROM_BANK_W'(1);
            r_ram_bank    <= '0;
        end else if (i_wr.wr) begin
            case (region)
                3'd0: r_ram_enabled <= (i_wr.write_value[3:0] == rrbc_pkg::RAM_EN_KEY);
                3'd1: begin
                    r_low_bank <= n_low_bank;
                    r_rom_bank <= n_rom_bank;
                end
                3'd2: begin
                    if (r_rom_mode) begin
                        r_high_bank <= n_high_bank;
                        r_rom_bank  <= n_rom_bank;
                    end else if (ram_sel_ok) begin
                        r_ram_bank  <= sel;
                    end
                end
                3'd3: r_rom_mode <= ~i_wr.write_value[0];
                default: ;
            endcase
        end
    end

    assign o_state.ram_enabled     = r_ram_enabled;
    assign o_state.active_rom_bank = r_rom_bank;
    assign o_state.active_ram_bank = r_ram_bank;

endmodule

>>> design/rrbc_ram.sv
`timescale 1ns / 1ps

module rrbc_ram #(
    parameter int RAM_BANKS = rrbc_pkg::RAM_BANKS_DEF,
    localparam int RAM_DEPTH = RAM_BANKS * rrbc_pkg::RAM_BANK_BYTES,
    localparam int RAM_AW    = $clog2(RAM_DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_en,
    input  logic                        i_rd_en,
    input  logic [RAM_AW-1:0]           i_addr,
    input  logic [rrbc_pkg::DATA_W-1:0] i_wdata,
    output logic [rrbc_pkg::DATA_W-1:0] o_rdata,
    output logic                        o_busy
);

    logic [rrbc_pkg::DATA_W-1:0] r_mem [0:RAM_DEPTH-1];
    logic [rrbc_pkg::DATA_W-1:0] r_rdata;
    logic                        r_clr_busy;
    logic [RAM_AW-1:0]           r_clr_addr;

    logic                        wr_en;
    logic [RAM_AW-1:0]           wr_addr;
    logic [rrbc_pkg::DATA_W-1:0] wr_data;

    // clearing pass after reset, one byte per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + RAM_AW'(1);
            if (r_clr_addr == RAM_AW'(RAM_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign wr_en   = r_clr_busy || i_wr_en;
    assign wr_addr = r_clr_busy ? r_clr_addr : i_addr;
    assign wr_data = r_clr_busy ? '0 : i_wdata;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr_busy;

endmodule

>>> design/rom_ram_bank_controller_top.sv
`timescale 1ns / 1ps
// reads pass the input register, then the result register, which waits for a free output
// throughput: one transaction per cycle, reads and writes alike, unless a read is stalled
// the ram read port is registered and updates in the same cycle as the result register
// reset: synchronous, active low; afterwards a clearing pass zeroes the ram,
// every byte of it, during which no transaction is accepted (config writes are)
module rom_ram_bank_controller_top #(
    parameter int RAM_BANKS = rrbc_pkg::RAM_BANKS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rrbc_in_if.snk                      i_in,
    rrbc_out_if.src                     o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rrbc_pkg::APB_AW-1:0] paddr,
    input  logic [rrbc_pkg::APB_DW-1:0] pwdata,
    output logic [rrbc_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    localparam int RAM_AW = $clog2(RAM_BANKS * rrbc_pkg::RAM_BANK_BYTES);

    rrbc_pkg::t_cfg        cfg;
    rrbc_pkg::t_bank_state bank;
    rrbc_pkg::t_bank_wr    bank_wr;

    logic                              r_in_valid;
    logic                              r_in_cmd;
    logic [rrbc_pkg::ADDR_W-1:0]       r_in_addr;
    logic [rrbc_pkg::DATA_W-1:0]       r_in_val;

    logic                              r_out_valid;
    logic [rrbc_pkg::SRC_W-1:0]        r_out_src;
    logic [rrbc_pkg::ROM_ADDR_W-1:0]   r_out_rom;
    logic [rrbc_pkg::DATA_W-1:0]       r_out_data;

    logic [rrbc_pkg::SRC_W-1:0]        n_out_src;
    logic [rrbc_pkg::ROM_ADDR_W-1:0]   n_out_rom;
    logic [rrbc_pkg::DATA_W-1:0]       n_out_data;

    logic                              out_free;
    logic                              process;
    logic                              is_write;
    logic                              ram_region;
    logic                              ram_on;
    logic                              ram_busy;
    logic [RAM_AW-1:0]                 ram_addr;
    logic [rrbc_pkg::DATA_W-1:0]       ram_rdata;

    rrbc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign out_free   = !r_out_valid || o_out.ready;
    assign is_write   = (r_in_cmd == rrbc_pkg::CMD_WRITE);
    assign process    = r_in_valid && (is_write || out_free);
    assign i_in.ready = !ram_busy && (!r_in_valid || process);

    assign ram_region = (r_in_addr[15:13] == 3'b101);
    assign ram_on     = cfg.has_ram && bank.ram_enabled;
    assign ram_addr   = RAM_AW'({bank.active_ram_bank,
                                 r_in_addr[rrbc_pkg::BANK_OFF_W-1:0]});

    assign bank_wr.wr          = process && is_write;
    assign bank_wr.bus_address = r_in_addr;
    assign bank_wr.write_value = r_in_val;

    rrbc_bank #(
        .RAM_BANKS (RAM_BANKS)
    ) u_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_wr    (bank_wr),
        .o_state (bank)
    );

    rrbc_ram #(
        .RAM_BANKS (RAM_BANKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (process && is_write && ram_region && ram_on),
        .i_rd_en (process && !is_write && ram_region && ram_on),
        .i_addr  (ram_addr),
        .i_wdata (r_in_val),
        .o_rdata (ram_rdata),
        .o_busy  (ram_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_cmd  <= i_in.cmd;
            r_in_addr <= i_in.bus_address;
            r_in_val  <= i_in.write_value;
        end
    end

    always_comb begin
        n_out_src  = rrbc_pkg::SRC_INVALID;
        n_out_rom  = '0;
        n_out_data = '0;
        if (!r_in_addr[15] && !r_in_addr[14]) begin
            n_out_src = rrbc_pkg::SRC_ROM;
            n_out_rom = rrbc_pkg::ROM_ADDR_W'(r_in_addr);
        end else if (!r_in_addr[15]) begin
            n_out_src = rrbc_pkg::SRC_ROM;
            n_out_rom = {bank.active_rom_bank, r_in_addr[rrbc_pkg::ROM_OFF_W-1:0]};
        end else if (ram_region) begin
            if (ram_on) begin
                n_out_src = rrbc_pkg::SRC_RAM;
            end else begin
                n_out_src  = rrbc_pkg::SRC_RAM_OFF;
                n_out_data = rrbc_pkg::RAM_OFF_DATA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process && !is_write) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && !is_write) begin
            r_out_src  <= n_out_src;
            r_out_rom  <= n_out_rom;
            r_out_data <= n_out_data;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.source      = r_out_src;
    assign o_out.rom_address = r_out_rom;
    assign o_out.read_data   = (r_out_src == rrbc_pkg::SRC_RAM) ? ram_rdata : r_out_data;

endmodule

>>> test/rrbc_bank_check.sv
`timescale 1ns / 1ps

module rrbc_bank_check (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rrbc_in_if                          i_in_mon,
    rrbc_out_if                         i_out_mon,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [rrbc_pkg::APB_AW-1:0] i_paddr,
    input  logic [rrbc_pkg::APB_DW-1:0] i_pwdata,
    output int                          o_fail_count,
    output int                          o_pending
);

    typedef struct packed {
        logic [rrbc_pkg::SRC_W-1:0]      source;
        logic [rrbc_pkg::ROM_ADDR_W-1:0] rom_address;
        logic [rrbc_pkg::DATA_W-1:0]     read_data;
    } t_read_result;

    logic [7:0] cfg_rom_banks;
    logic [2:0] cfg_ram_banks;
    logic       cfg_has_ram;

    logic                             ram_enabled;
    logic                             rom_mode;
    logic [rrbc_pkg::LOW_BANK_W-1:0]  low_bank;
    logic [rrbc_pkg::HIGH_BANK_W-1:0] high_bank;
    logic [rrbc_pkg::ROM_BANK_W-1:0]  rom_bank;
    logic [rrbc_pkg::RAM_SEL_W-1:0]   ram_bank;
    logic [rrbc_pkg::DATA_W-1:0]
        ram_image [rrbc_pkg::RAM_BANKS_DEF*rrbc_pkg::RAM_BANK_BYTES];

    t_read_result pending_reads [$];

    // bank mask comes from the count register, then limited to the 7-bit bank range
    function automatic logic [rrbc_pkg::ROM_BANK_W-1:0] masked_rom_bank(
        logic [rrbc_pkg::HIGH_BANK_W-1:0] hi,
        logic [rrbc_pkg::LOW_BANK_W-1:0]  lo,
        logic [7:0]                       count
    );
        logic [7:0] mask;
        mask = count - 8'd1;
        return {hi, lo} & mask[rrbc_pkg::ROM_BANK_W-1:0];
    endfunction

    task automatic decode_bus_access(input logic op,
                                     input logic [rrbc_pkg::ADDR_W-1:0] addr,
                                     input logic [rrbc_pkg::DATA_W-1:0] value);
        t_read_result res;
        res = '0;
        if (op == rrbc_pkg::CMD_WRITE) begin
            if (addr < 16'h2000) begin
                ram_enabled = (value[3:0] == rrbc_pkg::RAM_EN_KEY);
            end else if (addr < 16'h4000) begin
                low_bank = value[rrbc_pkg::LOW_BANK_W-1:0] & rrbc_pkg::LOW_BANK_MASK;
                if (low_bank == '0) begin
                    low_bank = 5'd1;
                end
                rom_bank = masked_rom_bank(high_bank, low_bank, cfg_rom_banks);
            end else if (addr < 16'h6000) begin
                if (rom_mode) begin
                    high_bank = value[rrbc_pkg::HIGH_BANK_W-1:0];
                    rom_bank  = masked_rom_bank(high_bank, low_bank, cfg_rom_banks);
                end else if ({1'b0, value[rrbc_pkg::RAM_SEL_W-1:0]} < cfg_ram_banks) begin
                    ram_bank = value[rrbc_pkg::RAM_SEL_W-1:0];
                end
            end else if (addr < 16'h8000) begin
                rom_mode = ~value[0];
            end else if (addr >= 16'hA000 && addr < 16'hC000
                         && cfg_has_ram && ram_enabled) begin
                ram_image[{ram_bank, addr[rrbc_pkg::BANK_OFF_W-1:0]}] = value;
            end
        end else begin
            if (addr < 16'h4000) begin
                res.source      = rrbc_pkg::SRC_ROM;
                res.rom_address = rrbc_pkg::ROM_ADDR_W'(addr);
            end else if (addr < 16'h8000) begin
                res.source      = rrbc_pkg::SRC_ROM;
                res.rom_address = {rom_bank, addr[rrbc_pkg::ROM_OFF_W-1:0]};
            end else if (addr >= 16'hA000 && addr < 16'hC000) begin
                if (!cfg_has_ram || !ram_enabled) begin
                    res.source    = rrbc_pkg::SRC_RAM_OFF;
                    res.read_data = rrbc_pkg::RAM_OFF_DATA;
                end else begin
                    res.source    = rrbc_pkg::SRC_RAM;
                    res.read_data = ram_image[{ram_bank, addr[rrbc_pkg::BANK_OFF_W-1:0]}];
                end
            end else begin
                res.source = rrbc_pkg::SRC_INVALID;
            end
            pending_reads.push_back(res);
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
            o_fail_count++;
        end
    endtask

    task automatic compare_read_result();
        t_read_result want;
        if (pending_reads.size() == 0) begin
            $display("%0t: unexpected result, source %0d rom_address 0x%0h read_data 0x%0h",
                     $time, i_out_mon.source, i_out_mon.rom_address, i_out_mon.read_data);
            o_fail_count++;
        end else begin
            want = pending_reads.pop_front();
            check_field("source", 32'(want.source), 32'(i_out_mon.source));
            check_field("rom_address", 32'(want.rom_address), 32'(i_out_mon.rom_address));
            check_field("read_data", 32'(want.read_data), 32'(i_out_mon.read_data));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_rom_banks = rrbc_pkg::ROM_BANK_COUNT_RST;
            cfg_ram_banks = rrbc_pkg::RAM_BANK_COUNT_RST;
            cfg_has_ram   = rrbc_pkg::HAS_RAM_RST;
            ram_enabled   = 1'b0;
            rom_mode      = 1'b1;
            low_bank      = 5'd1;
            high_bank     = '0;
            rom_bank      = 7'd1;
            ram_bank      = '0;
            foreach (ram_image[k]) ram_image[k] = '0;
            pending_reads.delete();
            o_fail_count  = 0;
            o_pending     = 0;
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                compare_read_result();
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                decode_bus_access(i_in_mon.cmd, i_in_mon.bus_address, i_in_mon.write_value);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr)
                    rrbc_pkg::REG_ROM_BANK_COUNT: cfg_rom_banks = i_pwdata[7:0];
                    rrbc_pkg::REG_RAM_BANK_COUNT: cfg_ram_banks = i_pwdata[2:0];
                    rrbc_pkg::REG_HAS_RAM:        cfg_has_ram   = i_pwdata[0];
                    default: ;
                endcase
            end
            o_pending = pending_reads.size();
        end
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_PERIOD      = 10;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 155;
    localparam int HOLD_CYCLES     = 400;
    localparam int TIMEOUT_NS      = 5_000_000;

    localparam logic [7:0] PHASE_ROM_BANKS [NUM_PHASES] =
        '{8'd128, 8'd0, 8'd255, 8'd2, 8'd1, 8'd3, 8'd64, 8'd128};
    localparam logic [2:0] PHASE_RAM_BANKS [NUM_PHASES] =
        '{3'd4, 3'd0, 3'd7, 3'd1, 3'd2, 3'd3, 3'd4, 3'd4};
    localparam logic       PHASE_HAS_RAM   [NUM_PHASES] =
        '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};

    logic i_clk;
    logic i_rst_n;

    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [rrbc_pkg::APB_AW-1:0] paddr;
    logic [rrbc_pkg::APB_DW-1:0] pwdata;
    logic [rrbc_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    int   fail_count;
    int   pending;
    logic quiet_run;
    logic hold_request;

    rrbc_in_if  in_if ();
    rrbc_out_if out_if ();

    rom_ram_bank_controller_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rrbc_bank_check bank_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_if),
        .i_out_mon    (out_if),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    initial begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

    task automatic write_cart_reg(input logic [rrbc_pkg::APB_AW-1:0] addr,
                                  input logic [rrbc_pkg::APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_access(input logic op, input logic [rrbc_pkg::ADDR_W-1:0] addr,
                               input logic [rrbc_pkg::DATA_W-1:0] value);
        if (!quiet_run && $urandom_range(0, 7) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.cmd         <= op;
        in_if.bus_address <= addr;
        in_if.write_value <= value;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // mostly small offsets at either end of a bank so that reads hit written bytes
    function automatic logic [rrbc_pkg::ADDR_W-1:0] pick_ram_address();
        logic [12:0] offset;
        offset = 13'($urandom_range(0, 13'h1FFF));
        if ($urandom_range(0, 3) != 0) begin
            offset = {($urandom_range(0, 1) != 0) ? 9'h1FF : 9'h000, 4'($urandom_range(0, 15))};
        end
        return {3'b101, offset};
    endfunction

    task automatic send_random_access();
        int                          pick;
        logic [rrbc_pkg::DATA_W-1:0] value;
        logic [rrbc_pkg::ADDR_W-1:0] addr;
        pick  = $urandom_range(0, 99);
        value = rrbc_pkg::DATA_W'($urandom_range(0, 255));
        if (pick < 8) begin
            if ($urandom_range(0, 3) != 0) begin
                value[3:0] = rrbc_pkg::RAM_EN_KEY;
            end
            send_access(rrbc_pkg::CMD_WRITE, 16'($urandom_range(16'h0000, 16'h1FFF)), value);
        end else if (pick < 16) begin
            send_access(rrbc_pkg::CMD_WRITE, 16'($urandom_range(16'h2000, 16'h3FFF)), value);
        end else if (pick < 24) begin
            send_access(rrbc_pkg::CMD_WRITE, 16'($urandom_range(16'h4000, 16'h5FFF)), value);
        end else if (pick < 29) begin
            send_access(rrbc_pkg::CMD_WRITE, 16'($urandom_range(16'h6000, 16'h7FFF)), value);
        end else if (pick < 48) begin
            send_access(rrbc_pkg::CMD_WRITE, pick_ram_address(), value);
        end else if (pick < 58) begin
            send_access(rrbc_pkg::CMD_READ, 16'($urandom_range(16'h0000, 16'h7FFF)), value);
        end else if (pick < 88) begin
            send_access(rrbc_pkg::CMD_READ, pick_ram_address(), value);
        end else if (pick < 94) begin
            if ($urandom_range(0, 1) != 0) begin
                addr = 16'($urandom_range(16'h8000, 16'h9FFF));
            end else begin
                addr = 16'($urandom_range(16'hC000, 16'hFFFF));
            end
            send_access(rrbc_pkg::CMD_READ, addr, value);
        end else begin
            send_access(1'($urandom_range(0, 1)), 16'($urandom_range(0, 16'hFFFF)), value);
        end
    endtask

    initial begin : result_sink
        out_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(0, 14)) @(negedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin : bus_stimulus
        i_rst_n           = 1'b0;
        quiet_run         = 1'b0;
        hold_request      = 1'b0;
        in_if.valid       = 1'b0;
        in_if.cmd         = rrbc_pkg::CMD_READ;
        in_if.bus_address = '0;
        in_if.write_value = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            quiet_run = (ph == 5 || ph == NUM_PHASES - 1);
            wait (pending == 0);
            repeat (4) @(negedge i_clk);
            write_cart_reg(rrbc_pkg::REG_ROM_BANK_COUNT,
                           rrbc_pkg::APB_DW'(PHASE_ROM_BANKS[ph]));
            write_cart_reg(rrbc_pkg::REG_RAM_BANK_COUNT,
                           rrbc_pkg::APB_DW'(PHASE_RAM_BANKS[ph]));
            write_cart_reg(rrbc_pkg::REG_HAS_RAM, rrbc_pkg::APB_DW'(PHASE_HAS_RAM[ph]));

            if (ph == 0) begin
                // rom window edges and invalid areas
                send_access(rrbc_pkg::CMD_READ, 16'h0000, 8'h00);
                send_access(rrbc_pkg::CMD_READ, 16'h3FFF, 8'hFF);
                send_access(rrbc_pkg::CMD_READ, 16'h4000, 8'h00);
                send_access(rrbc_pkg::CMD_READ, 16'h7FFF, 8'h00);
                send_access(rrbc_pkg::CMD_READ, 16'h8000, 8'h00);
                send_access(rrbc_pkg::CMD_READ, 16'hFFFF, 8'h00);
                // ram disabled reads 0xff, then enabled ram is written and read back
                send_access(rrbc_pkg::CMD_READ, 16'hA000, 8'h00);
                send_access(rrbc_pkg::CMD_WRITE, 16'h0000, 8'h0A);
                send_access(rrbc_pkg::CMD_WRITE, 16'hA000, 8'h5A);
                send_access(rrbc_pkg::CMD_WRITE, 16'hBFFF, 8'hA5);
                send_access(rrbc_pkg::CMD_READ, 16'hA000, 8'h00);
                send_access(rrbc_pkg::CMD_READ, 16'hBFFF, 8'h00);
                // bank 0 remaps to 1, then the largest bank
                send_access(rrbc_pkg::CMD_WRITE, 16'h2000, 8'h00);
                send_access(rrbc_pkg::CMD_READ, 16'h4000, 8'h00);
                send_access(rrbc_pkg::CMD_WRITE, 16'h3FFF, 8'hFF);
                send_access(rrbc_pkg::CMD_WRITE, 16'h4000, 8'hFF);
                send_access(rrbc_pkg::CMD_READ, 16'h7FFF, 8'h00);
                // ram banking mode, bank select, mode switch back keeps rom bank
                send_access(rrbc_pkg::CMD_WRITE, 16'h6000, 8'h01);
                send_access(rrbc_pkg::CMD_WRITE, 16'h5FFF, 8'h02);
                send_access(rrbc_pkg::CMD_WRITE, 16'hA123, 8'h77);
                send_access(rrbc_pkg::CMD_READ, 16'hA123, 8'h00);
                send_access(rrbc_pkg::CMD_WRITE, 16'h4000, 8'h00);
                send_access(rrbc_pkg::CMD_READ, 16'hA123, 8'h00);
                send_access(rrbc_pkg::CMD_WRITE, 16'h7FFF, 8'h00);
                send_access(rrbc_pkg::CMD_READ, 16'h4000, 8'h00);
                // disable again, ignored write addresses
                send_access(rrbc_pkg::CMD_WRITE, 16'h1FFF, 8'h1B);
                send_access(rrbc_pkg::CMD_WRITE, 16'hC000, 8'h55);
                send_access(rrbc_pkg::CMD_READ, 16'hBFFF, 8'h00);
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 2 && n == 40) begin
                    hold_request = 1'b1;
                end
                if (ph == 4 && n == 70) begin
                    in_if.valid <= 1'b0;
                    wait (pending == 0);
                    @(negedge i_clk);
                end
                send_random_access();
            end
            in_if.valid <= 1'b0;
        end

        wait (pending == 0);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
